// ===== src/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the block.
package lkv_pkg;

    localparam int LKV_MAX_ENTRIES = 16;
    localparam int LKV_DATA_W      = 32;
    localparam int LKV_CAP_W       = 5;
    localparam int LKV_PADDR_W     = 3;
    localparam int LKV_PDATA_W     = 32;

    localparam logic [LKV_CAP_W-1:0]  LKV_CAP_RESET  = 5'd16;
    localparam logic [LKV_DATA_W-1:0] LKV_MISS_VALUE = '1;   // -1 on a miss

    typedef enum logic [0:0] {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } lkv_cmd_t;

    // register index, taken from the word address
    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0
    } lkv_reg_t;

    typedef struct packed {
        lkv_cmd_t                     cmd;
        logic signed [LKV_DATA_W-1:0] key;
        logic signed [LKV_DATA_W-1:0] value;
    } lkv_req_t;

    typedef struct packed {
        logic                         found;
        logic signed [LKV_DATA_W-1:0] read_value;
    } lkv_rsp_t;

endpackage

// ===== src/lkv_cfg.sv =====
// APB-style register port holding the capacity register.
// Depends on lkv_pkg.
module lkv_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::LKV_PADDR_W-1:0]   paddr,
    input  logic [lkv_pkg::LKV_PDATA_W-1:0]   pwdata,
    output logic [lkv_pkg::LKV_PDATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [lkv_pkg::LKV_CAP_W-1:0]     capacity
);
    import lkv_pkg::*;

    logic [LKV_CAP_W-1:0] cap_reg;
    logic [LKV_CAP_W-1:0] cap_next;
    logic                 sel_cap;

    assign pready  = 1'b1;
    assign sel_cap = (paddr[2] == REG_CAPACITY);

    always_comb begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && sel_cap) begin
            cap_next = pwdata[LKV_CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= LKV_CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    assign prdata   = sel_cap ? LKV_PDATA_W'(cap_reg) : '0;
    assign capacity = cap_reg;

endmodule

// ===== src/lkv_store.sv =====
// Register CAM with per-entry recency ranks: lookup, touch, insert, evict.
// Depends on lkv_pkg. State updates at the clock edge that ends the request cycle.
module lkv_store #(
    parameter int MAX_ENTRIES = lkv_pkg::LKV_MAX_ENTRIES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                req_vld,
    input  lkv_pkg::lkv_req_t                   req,
    input  logic [lkv_pkg::LKV_CAP_W-1:0]       capacity,
    output lkv_pkg::lkv_rsp_t                   rsp,
    output logic [MAX_ENTRIES-1:0]              occupied,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]    count
);
    import lkv_pkg::*;

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > LKV_CAP_W) ? CW : LKV_CAP_W;

    logic [LKV_DATA_W-1:0] key_reg [MAX_ENTRIES];
    logic [LKV_DATA_W-1:0] val_reg [MAX_ENTRIES];
    logic [AW-1:0]         age_reg [MAX_ENTRIES];
    logic [AW-1:0]         age_next[MAX_ENTRIES];
    logic [AW-1:0]         age1    [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next, valid1;
    logic [CW-1:0]          count_reg, count_next, count1;

    logic [MAX_ENTRIES-1:0] hit_vec, oldest_vec, free_sel, ins_sel, evict_vec;
    logic                   hit, full, is_put, do_hit, do_ins, evict;
    logic [AW-1:0]          hit_age;
    logic [LKV_DATA_W-1:0]  hit_value;

    // match and read
    always_comb begin
        hit_age   = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_vec[i]    = valid_reg[i] && (key_reg[i] == req.key);
            oldest_vec[i] = valid_reg[i] && (CW'(age_reg[i]) == count_reg - CW'(1));
            if (hit_vec[i]) begin
                hit_age   = hit_age | age_reg[i];
                hit_value = hit_value | val_reg[i];
            end
        end
    end

    assign hit      = |hit_vec;
    assign full     = &valid_reg;
    assign free_sel = ~valid_reg & (valid_reg + MAX_ENTRIES'(1));   // lowest free slot
    assign ins_sel  = full ? oldest_vec : free_sel;                 // full: replace oldest
    assign is_put   = req_vld && (req.cmd == CMD_PUT);
    assign do_hit   = req_vld && hit;
    assign do_ins   = is_put && !hit;

    // touch or insert
    always_comb begin
        valid1 = valid_reg;
        count1 = count_reg;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            age1[i] = age_reg[i];
            if (do_hit) begin
                if (hit_vec[i]) begin
                    age1[i] = '0;
                end else if (valid_reg[i] && (age_reg[i] < hit_age)) begin
                    age1[i] = age_reg[i] + AW'(1);
                end
            end else if (do_ins) begin
                if (ins_sel[i]) begin
                    age1[i] = '0;
                end else if (valid_reg[i]) begin
                    age1[i] = age_reg[i] + AW'(1);
                end
            end
        end
        if (do_ins) begin
            valid1 = valid_reg | ins_sel;
            if (!full) begin
                count1 = count_reg + CW'(1);
            end
        end
    end

    // over capacity after a put: drop the least recent entry
    assign evict = is_put && (CMPW'(count1) > CMPW'(capacity));

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            evict_vec[i] = evict && valid1[i] && (CW'(age1[i]) == count1 - CW'(1));
            age_next[i]  = evict_vec[i] ? '0 : age1[i];
        end
        valid_next = valid1 & ~evict_vec;
        count_next = evict ? count1 - CW'(1) : count1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (is_put && (hit ? hit_vec[i] : ins_sel[i])) begin
                val_reg[i] <= req.value;
            end
            if (do_ins && ins_sel[i]) begin
                key_reg[i] <= req.key;
            end
        end
    end

    assign rsp.found      = hit;
    assign rsp.read_value = hit ? hit_value : LKV_MISS_VALUE;
    assign occupied       = valid_reg;
    assign count          = count_reg;

endmodule

// ===== src/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: input register, CAM store, result register.
// Depends on lkv_pkg, lkv_cfg and lkv_store.
//
// Fully associative key-value cache with least-recently-used replacement.
// Each item on the s_ stream is a get (tuser=0) or a put (tuser=1) with a
// 32-bit key and value in tdata. The store starts empty after reset. A get
// returns one item on the m_ stream: tuser=1 and the stored value on a hit,
// which also makes that entry most recent; tuser=0 and all ones on a miss.
// A put updates or inserts the key as most recent and returns nothing; when
// the entry count then exceeds the capacity register (address 0, reset 16,
// values above MAX_ENTRIES act as MAX_ENTRIES), the least recent entry is
// dropped. Throughput is one item per cycle unless stalled: an item is
// registered on acceptance, looked up and applied against all entries in
// parallel when it leaves the input register, and a get result appears in
// the output register in the cycle after that. The combinational CAM compare
// and rank update allow this rate; a get behind a held result (m_tready low)
// alone stalls the input. Change the capacity only while the block is idle.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkv_pkg::LKV_MAX_ENTRIES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]                        s_tuser,   // [0] cmd: 0 get, 1 put
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [31:0] read_value
    output logic [0:0]                        m_tuser,   // [0] found
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::LKV_PADDR_W-1:0]   paddr,
    input  logic [lkv_pkg::LKV_PDATA_W-1:0]   pwdata,
    output logic [lkv_pkg::LKV_PDATA_W-1:0]   prdata,
    output logic                              pready
);
    import lkv_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic                  in_vld_reg, in_vld_next;
    lkv_req_t              in_req_reg;
    logic                  out_vld_reg, out_vld_next;
    lkv_rsp_t              out_rsp_reg;
    lkv_rsp_t              rsp;
    logic [LKV_CAP_W-1:0]  capacity;
    logic [MAX_ENTRIES-1:0] occupied;
    logic [CW-1:0]         count;
    logic                  advance, get_fire, accept;

    lkv_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // a put always moves on; a get moves on when the result slot frees up
    assign advance  = in_vld_reg &&
                      ((in_req_reg.cmd == CMD_PUT) || !out_vld_reg || m_tready);
    assign get_fire = advance && (in_req_reg.cmd == CMD_GET);
    assign s_tready = !in_vld_reg || advance;
    assign accept   = s_tvalid && s_tready;

    lkv_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_vld  (advance),
        .req      (in_req_reg),
        .capacity (capacity),
        .rsp      (rsp),
        .occupied (occupied),
        .count    (count)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (accept) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (get_fire) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_req_reg.cmd   <= lkv_cmd_t'(s_tuser[0]);
            in_req_reg.key   <= s_tdata[31:0];
            in_req_reg.value <= s_tdata[63:32];
        end
        if (get_fire) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_rsp_reg.read_value;
    assign m_tuser  = out_rsp_reg.found;

    // entry count tracks the number of occupied slots
    a_count_matches : assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occupied) == 32'(count))
        else $error("entry count differs from occupied slots");

    // a result only appears after a get was applied
    a_result_from_get : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(get_fire))
        else $error("result without a get");

    // a put grows the store by at most one entry
    a_put_growth : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_req_reg.cmd == CMD_PUT)) |=>
        (32'(count) <= 32'($past(count)) + 32'd1))
        else $error("put added more than one entry");

endmodule
